### rtl/core/rpsg_pkg.sv
`default_nettype none

package rpsg_pkg;

  localparam int unsigned MaxPacketLen = 32;
  localparam int unsigned IdPacketLen  = 7;
  localparam int unsigned LenCmpW      = 8;

  localparam int unsigned IdW      = 48;
  localparam int unsigned RidW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 32;

  localparam logic [3:0] KbdLen   = 4'd8;
  localparam logic [3:0] ConsLen  = 4'd2;
  localparam logic [3:0] MouseLen = 4'd9;
  localparam logic [5:0] HidHdrLen = 6'd2;

  typedef enum logic [3:0] {
    MODE_UNPAIRED  = 4'b0001,
    MODE_PAIRING   = 4'b0010,
    MODE_VERIFYING = 4'b0100,
    MODE_PAIRED    = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    MCODE_UNPAIRED  = 2'd0,
    MCODE_PAIRING   = 2'd1,
    MCODE_VERIFYING = 2'd2,
    MCODE_PAIRED    = 2'd3
  } mode_code_e;

  typedef enum logic [3:0] {
    OP_START       = 4'd0,
    OP_SHORT_PRESS = 4'd1,
    OP_LONG_PRESS  = 4'd2,
    OP_BEACON      = 4'd3,
    OP_PAIR_RESP   = 4'd4,
    OP_HID         = 4'd5,
    OP_DISCONNECT  = 4'd6,
    OP_VERIFY_REQ  = 4'd7,
    OP_SHELL_START = 4'd8,
    OP_SHELL_STOP  = 4'd9,
    OP_GATED_CMD   = 4'd10,
    OP_OTHER       = 4'd11
  } opcode_e;

  typedef enum logic [2:0] {
    ACK_NONE       = 3'd0,
    ACK_PAIR_REQ   = 3'd1,
    ACK_DISCONNECT = 3'd2,
    ACK_RESYNC     = 3'd3,
    ACK_VERIFY     = 3'd4
  } ack_e;

  typedef enum logic [1:0] {
    STORE_NONE  = 2'd0,
    STORE_SAVE  = 2'd1,
    STORE_CLEAR = 2'd2
  } store_e;

  typedef enum logic [1:0] {
    RT_KEYBOARD = 2'd0,
    RT_CONSUMER = 2'd1,
    RT_MOUSE    = 2'd2,
    RT_UNKNOWN  = 2'd3
  } rtype_e;

  typedef enum logic [2:0] {
    CFG_OWN_ID       = 3'd0,
    CFG_STORED_VALID = 3'd1,
    CFG_STORED_ID    = 3'd2,
    CFG_AUTO_ARM     = 3'd3,
    CFG_KBD_ID       = 3'd4,
    CFG_CONS_ID      = 3'd5,
    CFG_MOUSE_ID     = 3'd6,
    CFG_RELAY_ON     = 3'd7
  } cfg_idx_e;

  // Last member sits in the lowest bits.
  typedef struct packed {
    logic [1:0]     rpt_kind;
    logic [IdW-1:0] sender_id;
    logic [5:0]     packet_len;
    logic [3:0]     opcode;
  } item_t;

  typedef struct packed {
    logic            stats_allowed;
    logic            relay_stop;
    logic            relay_request;
    logic            command_granted;
    logic [1:0]      store_action;
    logic [3:0]      host_rlen;
    logic [RidW-1:0] host_rid;
    logic            forward_report;
    logic            ack_pipe;
    logic [2:0]      ack_kind;
    logic [1:0]      mode_after;
  } result_t;

  typedef struct packed {
    logic            stored_valid;
    logic [IdW-1:0]  stored_id;
    logic            auto_arm;
    logic [RidW-1:0] kbd_id;
    logic [RidW-1:0] cons_id;
    logic [RidW-1:0] mouse_id;
    logic            relay_on;
  } cfg_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    c = MCODE_UNPAIRED;
    unique case (m)
      MODE_UNPAIRED:  c = MCODE_UNPAIRED;
      MODE_PAIRING:   c = MCODE_PAIRING;
      MODE_VERIFYING: c = MCODE_VERIFYING;
      MODE_PAIRED:    c = MCODE_PAIRED;
      default:        c = MCODE_UNPAIRED;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/radio_pairing_session_gate.sv
// Receiver-side pairing gate.
// Words come in on the s_axis channel, one event or received packet each, and
// every accepted word gives exactly one result word on the m_axis channel.
// The plain write port sets the seven configuration registers; write them
// only while no word is in flight.
// A word waits in the input register, where the decision logic reads it
// against the current mode and peer id; the result, the new mode and the
// new peer id are all registered at the same edge, when the word leaves the
// input register for the result register. While the receiver takes every
// result, one word per cycle is sustained.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; s_axis_tready drops only when both are
// full.
// Reset empties both registers, sets the mode to unpaired, clears the peer id
// and returns the configuration registers to their defaults.
`default_nettype none

module radio_pairing_session_gate
  import rpsg_pkg::*;
#(
  parameter int unsigned MaxPktLen = MaxPacketLen,
  parameter int unsigned IdPktLen  = IdPacketLen
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // opcode, packet_len, sender_id, rpt_kind, zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // mode_after, ack_kind, ack_pipe, forward_report, host_rid, host_rlen,
  // store_action, command_granted, relay_request, relay_stop, stats_allowed, zero fill
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t           cfg;
  logic           in_vld_q;
  item_t          item_q;
  logic           out_vld_q;
  result_t        res_q;
  result_t        res_d;
  mode_e          mode_q;
  mode_e          mode_d;
  logic [IdW-1:0] peer_q;
  logic [IdW-1:0] peer_d;
  logic           out_free;
  logic           advance;
  logic           in_take;

  rpsg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rpsg_decide #(
    .MaxPktLen (MaxPktLen),
    .IdPktLen  (IdPktLen)
  ) u_decide (
    .item_i (item_q),
    .cfg_i  (cfg),
    .mode_i (mode_q),
    .peer_i (peer_q),
    .mode_o (mode_d),
    .peer_o (peer_d),
    .res_o  (res_d)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_UNPAIRED;
      peer_q    <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        mode_q    <= mode_d;
        peer_q    <= peer_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  a_no_pipe_without_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_q.ack_kind == ACK_NONE) |-> !res_q.ack_pipe)
    else $error("ack pipe set without an acknowledgement");

  a_forward_only_paired : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.forward_report |-> (res_q.mode_after == MCODE_PAIRED))
    else $error("report forwarded outside paired mode");

  a_mode_tracks_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q.mode_after == mode_code(mode_q)))
    else $error("reported mode differs from held mode");

  a_save_sets_paired : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.store_action == STORE_SAVE) |=> (mode_q == MODE_PAIRED))
    else $error("pairing saved without entering paired mode");

endmodule

`default_nettype wire

### rtl/core/rpsg_cfg.sv
`default_nettype none

module rpsg_cfg
  import rpsg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stored_valid <= 1'b0;
      cfg_q.stored_id    <= '0;
      cfg_q.auto_arm     <= 1'b0;
      cfg_q.kbd_id       <= RidW'(1);
      cfg_q.cons_id      <= RidW'(2);
      cfg_q.mouse_id     <= RidW'(3);
      cfg_q.relay_on     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        // A write to the own id is ignored; no register in this block holds it.
        CFG_OWN_ID:       ;
        CFG_STORED_VALID: cfg_q.stored_valid <= cfg_data_i[0];
        CFG_STORED_ID:    cfg_q.stored_id    <= cfg_data_i[IdW-1:0];
        CFG_AUTO_ARM:     cfg_q.auto_arm     <= cfg_data_i[0];
        CFG_KBD_ID:       cfg_q.kbd_id       <= cfg_data_i[RidW-1:0];
        CFG_CONS_ID:      cfg_q.cons_id      <= cfg_data_i[RidW-1:0];
        CFG_MOUSE_ID:     cfg_q.mouse_id     <= cfg_data_i[RidW-1:0];
        CFG_RELAY_ON:     cfg_q.relay_on     <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/rpsg_decide.sv
`default_nettype none

module rpsg_decide
  import rpsg_pkg::*;
#(
  parameter int unsigned MaxPktLen = MaxPacketLen,
  parameter int unsigned IdPktLen  = IdPacketLen
) (
  input  wire item_t          item_i,
  input  wire cfg_t           cfg_i,
  input  wire mode_e          mode_i,
  input  wire logic [IdW-1:0] peer_i,
  output mode_e          mode_o,
  output logic [IdW-1:0] peer_o,
  output result_t        res_o
);

  logic [LenCmpW-1:0] len_ext;
  logic               is_packet;
  logic               pkt_ok;
  logic               id_len_ok;
  logic               counted;
  logic [RidW-1:0]    hid_id;
  logic [3:0]         hid_len;
  logic               hid_known;
  mode_e              mode_d;
  logic [IdW-1:0]     peer_d;
  result_t            res;

  assign len_ext   = LenCmpW'(item_i.packet_len);
  assign is_packet = item_i.opcode >= OP_BEACON;
  assign pkt_ok    = is_packet && (item_i.packet_len != '0)
                     && (len_ext <= LenCmpW'(MaxPktLen));
  assign id_len_ok = len_ext >= LenCmpW'(IdPktLen);

  always_comb begin
    hid_id    = cfg_i.kbd_id;
    hid_len   = KbdLen;
    hid_known = 1'b1;
    unique case (rtype_e'(item_i.rpt_kind))
      RT_KEYBOARD: begin
        hid_id  = cfg_i.kbd_id;
        hid_len = KbdLen;
      end
      RT_CONSUMER: begin
        hid_id  = cfg_i.cons_id;
        hid_len = ConsLen;
      end
      RT_MOUSE: begin
        hid_id  = cfg_i.mouse_id;
        hid_len = MouseLen;
      end
      default: hid_known = 1'b0;
    endcase
  end

  always_comb begin
    mode_d  = mode_i;
    peer_d  = peer_i;
    res     = '0;
    counted = 1'b0;
    if (item_i.opcode == OP_START) begin
      peer_d = cfg_i.stored_id;
      priority if (cfg_i.stored_valid) begin
        mode_d = MODE_VERIFYING;
      end else if (cfg_i.auto_arm) begin
        mode_d = MODE_PAIRING;
      end else begin
        mode_d = MODE_UNPAIRED;
      end
    end else if (item_i.opcode == OP_SHORT_PRESS) begin
      if (!cfg_i.auto_arm) begin
        if (mode_i == MODE_UNPAIRED) begin
          mode_d = MODE_PAIRING;
        end else if (mode_i == MODE_PAIRED) begin
          res.relay_request = 1'b1;
        end
      end
    end else if (item_i.opcode == OP_LONG_PRESS) begin
      if (!cfg_i.auto_arm && (mode_i == MODE_PAIRED || mode_i == MODE_VERIFYING)) begin
        res.store_action = STORE_CLEAR;
        peer_d           = '0;
        mode_d           = MODE_UNPAIRED;
        res.ack_kind     = ACK_DISCONNECT;
        res.ack_pipe     = 1'b1;
      end
    end else if (pkt_ok) begin
      counted = 1'b1;
      unique case (opcode_e'(item_i.opcode))
        OP_BEACON: begin
          if (mode_i == MODE_PAIRING) begin
            res.ack_kind = ACK_PAIR_REQ;
          end
        end
        OP_PAIR_RESP: begin
          if (mode_i == MODE_PAIRING && id_len_ok) begin
            peer_d            = item_i.sender_id;
            res.store_action  = STORE_SAVE;
            mode_d            = MODE_PAIRED;
            res.relay_request = cfg_i.relay_on;
          end
        end
        OP_HID: begin
          if (mode_i == MODE_VERIFYING) begin
            res.ack_kind = ACK_RESYNC;
            res.ack_pipe = 1'b1;
          end else if (mode_i == MODE_PAIRED && item_i.packet_len >= HidHdrLen) begin
            if (!hid_known) begin
              counted = 1'b0;
            end else if (item_i.packet_len >= (6'(hid_len) + HidHdrLen)) begin
              res.forward_report = 1'b1;
              res.host_rid       = hid_id;
              res.host_rlen      = hid_len;
            end
          end
        end
        OP_DISCONNECT: begin
          res.store_action = STORE_CLEAR;
          peer_d           = '0;
          mode_d           = MODE_UNPAIRED;
          res.relay_stop   = 1'b1;
        end
        OP_VERIFY_REQ: begin
          if (id_len_ok) begin
            res.ack_pipe = 1'b1;
            if ((item_i.sender_id == peer_i)
                && (mode_i == MODE_VERIFYING || mode_i == MODE_PAIRED)) begin
              res.ack_kind = ACK_VERIFY;
              if (mode_i == MODE_VERIFYING) begin
                mode_d            = MODE_PAIRED;
                res.relay_request = cfg_i.relay_on;
              end
            end else begin
              res.ack_kind = ACK_DISCONNECT;
            end
          end
        end
        OP_SHELL_START: begin
          res.relay_request = (mode_i == MODE_PAIRED);
        end
        OP_SHELL_STOP: begin
          res.relay_stop    = 1'b1;
          res.relay_request = cfg_i.relay_on && (mode_i == MODE_PAIRED);
        end
        OP_GATED_CMD: begin
          res.command_granted = (mode_i == MODE_PAIRED);
        end
        default: ;
      endcase
    end
    res.stats_allowed = counted && (mode_d == MODE_PAIRED);
    res.mode_after    = mode_code(mode_d);
  end

  assign mode_o = mode_d;
  assign peer_o = peer_d;
  assign res_o  = res;

endmodule

`default_nettype wire
